/* design/kwm_pkg.sv */
package kwm_pkg;

    // default sizing
    localparam int NUM_QUEUES_DEF  = 8;
    localparam int QUEUE_DEPTH_DEF = 64;

    // request codes
    localparam logic [1:0] REQ_APPEND = 2'd0;
    localparam logic [1:0] REQ_TAKE   = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;
    localparam logic [1:0] REQ_RSVD   = 2'd3;

    // result status codes
    typedef enum logic [2:0] {
        ST_APPENDED = 3'd0,
        ST_REJECTED = 3'd1,
        ST_TAKEN    = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_CLEARED  = 3'd4
    } t_status;

endpackage

/* design/k_way_sorted_merge.sv */
// Channel   Direction  Handshake                  Payload
// request   in         i_in_valid / o_in_stall    i_req_type, i_queue_index, i_item_value
// result    out        o_out_valid / i_out_stall  o_merged_value, o_source_queue, o_status
//
// A take runs a head scan: one queue per cycle through the control memory and then
// the value memory, each with a registered read, then a write-back state.
// i_rst_n (synchronous, low) empties every queue; the value memory is not cleared.
// A result waits in the output register while i_out_stall is high; the next request
// is taken meanwhile, and the block holds its finished result until the register frees.
module k_way_sorted_merge #(
    parameter int NUM_QUEUES  = kwm_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH = kwm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_req_type,
    input  logic [2:0]         i_queue_index,
    input  logic signed [31:0] i_item_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_merged_value,
    output logic [2:0]         o_source_queue,
    output logic [2:0]         o_status
);

    // widths
    localparam int QW  = $clog2(NUM_QUEUES);               // queue number
    localparam int PW  = $clog2(QUEUE_DEPTH);              // head pointer
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);          // fill count
    localparam int SW  = PW + 1;                           // head + fill
    localparam int CTW = PW + CW;                          // control word {head, fill}
    localparam int DD  = NUM_QUEUES * QUEUE_DEPTH;         // value memory depth
    localparam int DAW = $clog2(DD);

    typedef enum logic [2:0] {
        S_IDLE,
        S_APPEND,
        S_SCAN,
        S_COMMIT,
        S_DONE
    } t_state;

    t_state r_state;

    // per-queue live bits: a control entry not live reads as empty
    logic [NUM_QUEUES-1:0] r_live;

    // control memory ports
    logic           c_re, c_we;
    logic [QW-1:0]  c_raddr, c_waddr;
    logic [CTW-1:0] c_wdata, c_rdata;
    // value memory ports
    logic           d_re, d_we;
    logic [DAW-1:0] d_raddr, d_waddr;
    logic [31:0]    d_rdata;

    // registers of the sequencer
    logic [QW-1:0]      r_q;          // append target
    logic signed [31:0] r_val;        // append value
    logic [QW-1:0]      r_iss;        // scan: next control read
    logic               r_iss_on;
    logic               r_s1_v;       // scan: control data due
    logic [QW-1:0]      r_s1_q;
    logic               r_s2_v;       // scan: head value due
    logic [QW-1:0]      r_s2_q;
    logic               r_s2_ne;
    logic [PW-1:0]      r_s2_head;
    logic [CW-1:0]      r_s2_fill;
    logic               r_found;
    logic signed [31:0] r_best_val;
    logic [QW-1:0]      r_best_q;
    logic [PW-1:0]      r_best_head;
    logic [CW-1:0]      r_best_fill;
    // finished result, waiting for the output register
    logic signed [31:0] r_pend_val;
    logic [2:0]         r_pend_q;
    kwm_pkg::t_status   r_pend_st;
    // output register
    logic               r_out_valid;
    logic signed [31:0] r_out_val;
    logic [2:0]         r_out_q;
    kwm_pkg::t_status   r_out_st;

    logic          accept;
    logic          idx_ok;
    logic          live_rd;
    logic [PW-1:0] ctl_head;
    logic [CW-1:0] ctl_fill;
    logic [SW-1:0] tail_sum;
    logic [PW-1:0] tail;
    logic [PW-1:0] best_head_nx;
    logic          s2_better;
    logic          out_free;

    function automatic logic [DAW-1:0] val_addr(input logic [QW-1:0] q,
                                                 input logic [PW-1:0] p);
        return DAW'(DAW'(q) * DAW'(QUEUE_DEPTH) + DAW'(p));
    endfunction

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign idx_ok   = int'(i_queue_index) < NUM_QUEUES;
    assign out_free = !r_out_valid || !i_out_stall;

    // control read data, seen through the live bit of the queue it belongs to
    assign live_rd  = (r_state == S_APPEND) ? r_live[r_q] : r_live[r_s1_q];
    assign ctl_head = live_rd ? c_rdata[CTW-1:CW] : '0;
    assign ctl_fill = live_rd ? c_rdata[CW-1:0] : '0;

    // tail slot of an append; fill is below depth here, so one subtract suffices
    always_comb begin
        tail_sum = SW'(ctl_head) + SW'(ctl_fill);
        if (tail_sum >= SW'(QUEUE_DEPTH)) begin
            tail_sum = tail_sum - SW'(QUEUE_DEPTH);
        end
        tail = tail_sum[PW-1:0];
    end

    assign best_head_nx = (r_best_head == PW'(QUEUE_DEPTH - 1)) ? '0 : r_best_head + 1'b1;

    // strict less: on a tie the earlier (lower) queue stays
    assign s2_better = r_s2_v && r_s2_ne &&
                       (!r_found || ($signed(d_rdata) < r_best_val));

    // memory ports; reads and writes never fall in the same cycle, so no forwarding
    always_comb begin
        c_re    = 1'b0;
        c_raddr = r_iss;
        c_we    = 1'b0;
        c_waddr = r_q;
        c_wdata = {ctl_head, CW'(ctl_fill + 1'b1)};
        d_re    = 1'b0;
        d_raddr = val_addr(r_s1_q, ctl_head);
        d_we    = 1'b0;
        d_waddr = val_addr(r_q, tail);
        case (r_state)
            S_IDLE: begin
                if (accept && (i_req_type == kwm_pkg::REQ_APPEND) && idx_ok) begin
                    c_re    = 1'b1;
                    c_raddr = QW'(i_queue_index);
                end
            end
            S_APPEND: begin
                if (ctl_fill < CW'(QUEUE_DEPTH)) begin
                    c_we = 1'b1;
                    d_we = 1'b1;
                end
            end
            S_SCAN: begin
                c_re = r_iss_on;
                d_re = r_s1_v && (ctl_fill != '0);
            end
            S_COMMIT: begin
                c_we    = r_found;
                c_waddr = r_best_q;
                c_wdata = {best_head_nx, CW'(r_best_fill - 1'b1)};
            end
            default: begin
            end
        endcase
    end

    kwm_ram #(
        .WIDTH(CTW),
        .DEPTH(NUM_QUEUES)
    ) u_ctl_ram (
        .i_clk  (i_clk),
        .i_we   (c_we),
        .i_waddr(c_waddr),
        .i_wdata(c_wdata),
        .i_re   (c_re),
        .i_raddr(c_raddr),
        .o_rdata(c_rdata)
    );

    kwm_ram #(
        .WIDTH(32),
        .DEPTH(DD)
    ) u_val_ram (
        .i_clk  (i_clk),
        .i_we   (d_we),
        .i_waddr(d_waddr),
        .i_wdata(r_val),
        .i_re   (d_re),
        .i_raddr(d_raddr),
        .o_rdata(d_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_live      <= '0;
            r_iss_on    <= 1'b0;
            r_s1_v      <= 1'b0;
            r_s2_v      <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // a result leaving with nothing to replace it empties the register
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (i_req_type)
                            kwm_pkg::REQ_APPEND: begin
                                r_q   <= QW'(i_queue_index);
                                r_val <= i_item_value;
                                if (idx_ok) begin
                                    r_state <= S_APPEND;
                                end else begin
                                    r_pend_val <= '0;
                                    r_pend_q   <= '0;
                                    r_pend_st  <= kwm_pkg::ST_REJECTED;
                                    r_state    <= S_DONE;
                                end
                            end
                            kwm_pkg::REQ_TAKE: begin
                                r_iss    <= '0;
                                r_iss_on <= 1'b1;
                                r_s1_v   <= 1'b0;
                                r_s2_v   <= 1'b0;
                                r_found  <= 1'b0;
                                r_state  <= S_SCAN;
                            end
                            kwm_pkg::REQ_CLEAR, kwm_pkg::REQ_RSVD: begin
                                // reserved code clears as well
                                r_live     <= '0;
                                r_pend_val <= '0;
                                r_pend_q   <= '0;
                                r_pend_st  <= kwm_pkg::ST_CLEARED;
                                r_state    <= S_DONE;
                            end
                            default: begin
                                r_live     <= '0;
                                r_pend_val <= '0;
                                r_pend_q   <= '0;
                                r_pend_st  <= kwm_pkg::ST_CLEARED;
                                r_state    <= S_DONE;
                            end
                        endcase
                    end
                end
                S_APPEND: begin
                    r_pend_val <= '0;
                    r_pend_q   <= '0;
                    if (ctl_fill < CW'(QUEUE_DEPTH)) begin
                        r_live[r_q] <= 1'b1;
                        r_pend_st   <= kwm_pkg::ST_APPENDED;
                    end else begin
                        r_pend_st <= kwm_pkg::ST_REJECTED;
                    end
                    r_state <= S_DONE;
                end
                S_SCAN: begin
                    // issue stage
                    r_s1_v <= r_iss_on;
                    r_s1_q <= r_iss;
                    if (r_iss_on) begin
                        if (r_iss == QW'(NUM_QUEUES - 1)) begin
                            r_iss_on <= 1'b0;
                        end else begin
                            r_iss <= r_iss + 1'b1;
                        end
                    end
                    // control data stage
                    r_s2_v    <= r_s1_v;
                    r_s2_q    <= r_s1_q;
                    r_s2_ne   <= ctl_fill != '0;
                    r_s2_head <= ctl_head;
                    r_s2_fill <= ctl_fill;
                    // compare stage
                    if (s2_better) begin
                        r_found     <= 1'b1;
                        r_best_val  <= $signed(d_rdata);
                        r_best_q    <= r_s2_q;
                        r_best_head <= r_s2_head;
                        r_best_fill <= r_s2_fill;
                    end
                    if (r_s2_v && (r_s2_q == QW'(NUM_QUEUES - 1))) begin
                        r_state <= S_COMMIT;
                    end
                end
                S_COMMIT: begin
                    if (r_found) begin
                        r_pend_val <= r_best_val;
                        r_pend_q   <= 3'(r_best_q);
                        r_pend_st  <= kwm_pkg::ST_TAKEN;
                    end else begin
                        r_pend_val <= '0;
                        r_pend_q   <= '0;
                        r_pend_st  <= kwm_pkg::ST_EMPTY;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_val   <= r_pend_val;
                        r_out_q     <= r_pend_q;
                        r_out_st    <= r_pend_st;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall     = r_state != S_IDLE;
    assign o_out_valid    = r_out_valid;
    assign o_merged_value = r_out_val;
    assign o_source_queue = r_out_q;
    assign o_status       = r_out_st;

endmodule

/* design/kwm_ram.sv */
module kwm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds while no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/kwm_checker.sv */
module kwm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [31:0] o_merged_value,
    input logic [2:0]         o_source_queue,
    input logic [2:0]         o_status
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_merged_value)
            && $stable(o_source_queue) && $stable(o_status))
        else $error("stalled result changed");

    // only a take carries a value and a source queue
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != kwm_pkg::ST_TAKEN) |->
            (o_merged_value == 0) && (o_source_queue == 3'd0))
        else $error("non-take result carries data");

    // one request at a time: busy right after a transfer in
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request taken while previous in progress");

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind k_way_sorted_merge kwm_checker u_kwm_checker (.*);

/* tb/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_QUEUES  = kwm_pkg::NUM_QUEUES_DEF;
    localparam int QUEUE_DEPTH = kwm_pkg::QUEUE_DEPTH_DEF;
    localparam int RUN_LIMIT   = 600000;     // cycles
    localparam int PHASE_ITEMS = 450;        // minimum per phase; three idling phases, at least 1350 random requests

    localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

    // one result transfer
    typedef struct packed {
        logic signed [31:0] value;
        logic [2:0]         src;
        kwm_pkg::t_status   status;
    } t_merge_result;

    // one directed request; want is used only where known is set
    typedef struct packed {
        logic [1:0]         req;
        logic [2:0]         qi;
        logic signed [31:0] val;
        logic               known;
        t_merge_result      want;
    } t_dir_row;

    localparam t_merge_result APPENDED_RES = '{32'sd0, 3'd0, kwm_pkg::ST_APPENDED};
    localparam t_merge_result CLEARED_RES  = '{32'sd0, 3'd0, kwm_pkg::ST_CLEARED};
    localparam t_merge_result EMPTY_RES    = '{32'sd0, 3'd0, kwm_pkg::ST_EMPTY};
    localparam t_merge_result ANY_RES      = '{32'sd0, 3'd0, kwm_pkg::ST_APPENDED};

    localparam logic [1:0] R_APP = kwm_pkg::REQ_APPEND;
    localparam logic [1:0] R_TAK = kwm_pkg::REQ_TAKE;
    localparam logic [1:0] R_CLR = kwm_pkg::REQ_CLEAR;
    localparam logic [1:0] R_RSV = kwm_pkg::REQ_RSVD;
    localparam kwm_pkg::t_status S_TAK = kwm_pkg::ST_TAKEN;

    // Directed walk: empty take after reset, extremes, ties, unsorted input,
    // reserved code acting as clear, ignored fields on take and clear.
    localparam t_dir_row DIR_TABLE [25] = '{
        '{R_TAK, 3'd0, 32'sd0,          1'b1, EMPTY_RES},
        '{R_CLR, 3'd0, 32'sd0,          1'b1, CLEARED_RES},
        '{R_APP, 3'd0, INT_MAX,         1'b1, APPENDED_RES},
        '{R_APP, 3'd7, INT_MIN,         1'b1, APPENDED_RES},
        '{R_APP, 3'd3, -32'sd1,         1'b1, APPENDED_RES},
        '{R_APP, 3'd3, 32'sd5,          1'b1, APPENDED_RES},
        '{R_APP, 3'd1, -32'sd1,         1'b1, APPENDED_RES},
        '{R_TAK, 3'd0, 32'sd0,          1'b1, '{INT_MIN, 3'd7, S_TAK}},
        // tie on -1: queue 1 beats queue 3
        '{R_TAK, 3'd0, 32'sd0,          1'b1, '{-32'sd1, 3'd1, S_TAK}},
        '{R_TAK, 3'd0, 32'sd0,          1'b1, '{-32'sd1, 3'd3, S_TAK}},
        // 2 after 5 on queue 3: out of order, still popped by head order
        '{R_APP, 3'd3, 32'sd2,          1'b1, APPENDED_RES},
        '{R_TAK, 3'd0, 32'sd0,          1'b1, '{32'sd5, 3'd3, S_TAK}},
        '{R_TAK, 3'd0, 32'sd0,          1'b1, '{32'sd2, 3'd3, S_TAK}},
        '{R_TAK, 3'd0, 32'sd0,          1'b1, '{INT_MAX, 3'd0, S_TAK}},
        '{R_TAK, 3'd0, 32'sd0,          1'b1, EMPTY_RES},
        '{R_APP, 3'd6, INT_MAX,         1'b1, APPENDED_RES},
        '{R_APP, 3'd2, INT_MAX,         1'b1, APPENDED_RES},
        '{R_TAK, 3'd0, 32'sd0,          1'b1, '{INT_MAX, 3'd2, S_TAK}},
        '{R_RSV, 3'd7, 32'sh1234_5678,  1'b1, CLEARED_RES},
        '{R_TAK, 3'd0, 32'sd0,          1'b1, EMPTY_RES},
        '{R_APP, 3'd4, 32'sh5555_5555,  1'b0, ANY_RES},
        '{R_APP, 3'd4, 32'shAAAA_AAAA,  1'b0, ANY_RES},
        '{R_APP, 3'd5, 32'sd0,          1'b0, ANY_RES},
        '{R_TAK, 3'd7, -32'sd1,         1'b0, ANY_RES},
        '{R_CLR, 3'd7, -32'sd1,         1'b1, CLEARED_RES}
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               req_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         req_type = kwm_pkg::REQ_APPEND;
    logic [2:0]         req_queue = 3'd0;
    logic signed [31:0] req_value = 32'sd0;
    logic               res_valid;
    logic               res_stall = 1'b0;
    logic signed [31:0] res_value;
    logic [2:0]         res_queue;
    logic [2:0]         res_status;

    // shadow of the queue memory, read pointers and occupancy
    logic signed [31:0] shadow_store [NUM_QUEUES][QUEUE_DEPTH];
    int                 shadow_head  [NUM_QUEUES];
    int                 shadow_fill  [NUM_QUEUES];

    t_merge_result      pending_results [$];
    int                 errors = 0;
    int                 sent = 0;
    int                 cycles = 0;
    int                 status_seen [8];
    int                 send_idle_pct = 32;
    int                 recv_idle_pct = 80;

    k_way_sorted_merge dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (req_valid),
        .o_in_stall     (in_stall),
        .i_req_type     (req_type),
        .i_queue_index  (req_queue),
        .i_item_value   (req_value),
        .o_out_valid    (res_valid),
        .i_out_stall    (res_stall),
        .o_merged_value (res_value),
        .o_source_queue (res_queue),
        .o_status       (res_status)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // Applies one request to the shadow state and returns the result it owes.
    function automatic t_merge_result merge_step(logic [1:0] req, logic [2:0] qi,
                                                 logic signed [31:0] val);
        t_merge_result r;
        int            best;
        r    = '{32'sd0, 3'd0, kwm_pkg::ST_APPENDED};
        best = -1;
        if (req[1]) begin
            // clear and the reserved code share bit 1
            for (int q = 0; q < NUM_QUEUES; q++) begin
                shadow_head[q] = 0;
                shadow_fill[q] = 0;
            end
            r.status = kwm_pkg::ST_CLEARED;
        end else if (req == kwm_pkg::REQ_TAKE) begin
            // strict less-than keeps the lowest queue on a tie
            for (int q = 0; q < NUM_QUEUES; q++) begin
                if (shadow_fill[q] != 0 && (best < 0 ||
                        shadow_store[q][shadow_head[q]] <
                        shadow_store[best][shadow_head[best]]))
                    best = q;
            end
            if (best < 0) begin
                r.status = kwm_pkg::ST_EMPTY;
            end else begin
                r.value = shadow_store[best][shadow_head[best]];
                r.src   = best[2:0];
                r.status = kwm_pkg::ST_TAKEN;
                shadow_head[best] = (shadow_head[best] + 1) % QUEUE_DEPTH;
                shadow_fill[best]--;
            end
        end else if (int'(qi) >= NUM_QUEUES || shadow_fill[qi] >= QUEUE_DEPTH) begin
            r.status = kwm_pkg::ST_REJECTED;
        end else begin
            shadow_store[qi][(shadow_head[qi] + shadow_fill[qi]) % QUEUE_DEPTH] = val;
            shadow_fill[qi]++;
        end
        return r;
    endfunction

    // Drives one request until its transfer. Called at a rising edge; valid is
    // only lowered for an idle gap, so back-to-back requests keep it high.
    task automatic push_request(logic [1:0] req, logic [2:0] qi, logic signed [31:0] val,
                                bit known = 1'b0, t_merge_result want = '0);
        t_merge_result predicted;
        bit            taken;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            req_valid <= 1'b0;
            req_type  <= 2'($urandom_range(0, 3));
            req_queue <= 3'($urandom_range(0, 7));
            req_value <= $urandom;
            @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_type  <= req;
        req_queue <= qi;
        req_value <= val;
        // sample at the falling edge, act at the next rising edge
        do begin
            @(negedge clk);
            taken = (in_stall === 1'b0);
            @(posedge clk);
        end while (!taken);
        predicted = merge_step(req, qi, val);
        pending_results.push_back(known ? want : predicted);
        sent++;
    endtask

    // Ascending lists on a random subset of queues, appended interleaved, then
    // drained with up to two takes past empty; now and then cut short by a clear.
    task automatic sorted_round();
        int  lists [NUM_QUEUES][$];
        int  total;
        int  appended;
        int  q;
        int  n;
        bit  narrow;
        total  = 0;
        narrow = ($urandom_range(0, 3) == 0);   // narrow range forces ties
        for (int i = 0; i < NUM_QUEUES; i++) begin
            if ($urandom_range(0, 1) == 1) begin
                n = $urandom_range(1, 10);
                for (int k = 0; k < n; k++)
                    lists[i].push_back(narrow ? int'($urandom_range(0, 15)) - 8
                                              : int'($urandom));
                lists[i].sort();
                total += n;
            end
        end
        appended = total;
        while (total > 0) begin
            q = $urandom_range(0, NUM_QUEUES - 1);
            if (lists[q].size() != 0) begin
                push_request(kwm_pkg::REQ_APPEND, q[2:0], lists[q].pop_front());
                total--;
            end
        end
        n = appended + $urandom_range(0, 2);
        for (int k = 0; k < n; k++) begin
            if (k == n / 2 && $urandom_range(0, 4) == 0) begin
                push_request($urandom_range(0, 1) ? kwm_pkg::REQ_CLEAR : kwm_pkg::REQ_RSVD,
                             3'($urandom_range(0, 7)), $urandom);
                break;
            end
            push_request(kwm_pkg::REQ_TAKE, 3'($urandom_range(0, 7)), $urandom);
        end
    endtask

    // Fills one queue past full, pops part of it, refills so the pointers wrap
    // and may overflow again, then clears.
    task automatic overflow_round();
        logic [2:0] q;
        int         n;
        q = 3'($urandom_range(0, NUM_QUEUES - 1));
        n = QUEUE_DEPTH + $urandom_range(1, 3);
        for (int k = 0; k < n; k++) push_request(kwm_pkg::REQ_APPEND, q, $urandom);
        n = $urandom_range(10, 40);
        for (int k = 0; k < n; k++)
            push_request(kwm_pkg::REQ_TAKE, 3'($urandom_range(0, 7)), $urandom);
        n = $urandom_range(10, 45);
        for (int k = 0; k < n; k++) push_request(kwm_pkg::REQ_APPEND, q, $urandom);
        push_request(kwm_pkg::REQ_CLEAR, 3'($urandom_range(0, 7)), $urandom);
    endtask

    // Unordered requests with random fields.
    task automatic noise_round();
        int n;
        int pick;
        n = $urandom_range(1, 20);
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 9);
            push_request(pick < 4 ? kwm_pkg::REQ_APPEND : pick < 8 ? kwm_pkg::REQ_TAKE :
                         pick == 8 ? kwm_pkg::REQ_CLEAR : kwm_pkg::REQ_RSVD,
                         3'($urandom_range(0, 7)), $urandom);
        end
    endtask

    task automatic run_phase(int s_pct, int r_pct);
        int start;
        int pick;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        start = sent;
        overflow_round();
        while (sent - start < PHASE_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                sorted_round();
            else if (pick == 6)
                overflow_round();
            else
                noise_round();
        end
    endtask

    task automatic report_mismatch(string what, t_merge_result want, t_merge_result got);
        errors++;
        if (errors <= 10)
            $display({"%0t: %s: expected value %0d queue %0d status %0d, ",
                      "got value %0d queue %0d status %0d"},
                     $realtime, what, want.value, want.src, want.status,
                     got.value, got.src, got.status);
    endtask

    // Result side: sample at the falling edge, the transfer lands at the
    // next rising edge, then pick the stall for the following cycle.
    always begin : result_sink
        t_merge_result got;
        t_merge_result want;
        bit            fire;
        @(negedge clk);
        fire = rst_n && res_valid === 1'b1 && res_stall == 1'b0;
        got  = '{res_value, res_queue, kwm_pkg::t_status'(res_status)};
        @(posedge clk);
        if (fire) begin
            status_seen[got.status]++;
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing outstanding", '0, got);
            end else begin
                want = pending_results.pop_front();
                if (got.value !== want.value || got.src !== want.src ||
                        got.status !== want.status)
                    report_mismatch("result mismatch", want, got);
            end
        end
        res_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycles, pending_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIR_TABLE[i])
            push_request(DIR_TABLE[i].req, DIR_TABLE[i].qi, DIR_TABLE[i].val,
                         DIR_TABLE[i].known, DIR_TABLE[i].want);

        // sender sparse and receiver mostly stalled, then the reverse, then flat out
        run_phase(32, 80);
        run_phase(80, 32);
        run_phase(0, 0);

        req_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        // margin past the longest request, a take; anything stray shows up by then
        repeat (NUM_QUEUES + 8) @(posedge clk);

        $display("Covered %0d request transfers: %0d appends, %0d full-queue rejections",
                 sent, status_seen[kwm_pkg::ST_APPENDED], status_seen[kwm_pkg::ST_REJECTED]);
        $display("Clears %0d, merged takes %0d, takes on all-empty %0d, mismatches %0d",
                 status_seen[kwm_pkg::ST_CLEARED], status_seen[kwm_pkg::ST_TAKEN],
                 status_seen[kwm_pkg::ST_EMPTY], errors);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* files.f */
design/kwm_pkg.sv
design/kwm_ram.sv
design/k_way_sorted_merge.sv
design/kwm_checker.sv
tb/tb_top.sv
